// ===== hw/rtl/pcf_pkg.sv =====
`timescale 1ns / 1ps

package pcf_pkg;

    // Input command codes
    localparam logic [1:0] CMD_KEY    = 2'd0;
    localparam logic [1:0] CMD_FINISH = 2'd1;
    localparam logic [1:0] CMD_PAIR   = 2'd2;
    localparam logic [1:0] CMD_NONE   = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_NOT_READY = 2'd1;
    localparam logic [1:0] ST_DUPLICATE = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    // Result source select
    localparam logic [1:0] RES_EXEC = 2'd0;
    localparam logic [1:0] RES_SQ   = 2'd1;
    localparam logic [1:0] RES_FIN  = 2'd2;

    // Square geometry and letter codes
    localparam int unsigned SIDE        = 5;
    localparam int unsigned CELLS       = SIDE * SIDE;
    localparam int unsigned LETTERS     = 26;
    localparam logic [4:0]  LETTER_I    = 5'd8;
    localparam logic [4:0]  LETTER_J    = 5'd9;
    localparam logic [4:0]  LAST_LETTER = 5'd25;
    localparam logic [4:0]  CELLS_5B    = 5'(CELLS);
    localparam logic [2:0]  SIDE_LAST   = 3'(SIDE - 1);

    // Commands from controller to datapath
    typedef struct packed {
        logic       capture;
        logic       fire;
        logic       sq_read;
        logic       walk_start;
        logic       walk_step;
        logic [1:0] res_sel;
    } ctrl_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic [1:0] cmd;
        logic       square_ready;
        logic       walk_last;
    } dp_stat_t;

endpackage

// ===== hw/rtl/pcf_ctrl.sv =====
`timescale 1ns / 1ps

module pcf_ctrl import pcf_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    output logic       m_valid,
    input  logic       m_ready,
    input  dp_stat_t   stat,
    output ctrl_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_SQ   = 3'd2;
    localparam logic [2:0] S_WALK = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       done;
    logic       out_free;
    logic       accept;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE) || (done && out_free);
    assign accept   = s_valid && s_ready;
    assign m_valid  = m_valid_reg;

    // Decode state into datapath commands
    always_comb begin
        done           = 1'b0;
        cmd            = '0;
        cmd.res_sel    = RES_EXEC;
        cmd.capture    = accept;
        state_next     = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                case (stat.cmd)
                    CMD_FINISH: begin
                        if (stat.square_ready) begin
                            done = 1'b1;
                        end else begin
                            cmd.walk_start = 1'b1;
                            state_next     = S_WALK;
                        end
                    end
                    CMD_PAIR: begin
                        if (stat.square_ready) begin
                            cmd.sq_read = 1'b1;
                            state_next  = S_SQ;
                        end else begin
                            done = 1'b1;
                        end
                    end
                    default: begin
                        done = 1'b1;
                    end
                endcase
            end
            S_SQ: begin
                done        = 1'b1;
                cmd.res_sel = RES_SQ;
            end
            S_WALK: begin
                cmd.walk_step = 1'b1;
                if (stat.walk_last) begin
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                done        = 1'b1;
                cmd.res_sel = RES_FIN;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
        cmd.fire = done && out_free;
        if (cmd.fire) begin
            state_next = accept ? S_EXEC : S_IDLE;
        end
    end

    // Hold the result valid until the receiver takes the transaction
    always_comb begin
        if (cmd.fire) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// ===== hw/rtl/pcf_datapath.sv =====
`timescale 1ns / 1ps

module pcf_datapath import pcf_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    input  logic [1:0] s_command,
    input  logic [4:0] s_letter_a,
    input  logic [4:0] s_letter_b,
    output logic [4:0] m_out_a,
    output logic [4:0] m_out_b,
    output logic [1:0] m_status,
    input  ctrl_cmd_t  cmd,
    output dp_stat_t   stat
);

    // Saturate to z, then fold j onto i
    function automatic logic [4:0] norm_letter(input logic [4:0] v);
        logic [4:0] c;
        c = (v > LAST_LETTER) ? LAST_LETTER : v;
        return (c == LETTER_J) ? LETTER_I : c;
    endfunction

    // Step a row or column index by one, wrapping at the square edge
    function automatic logic [2:0] step_idx(input logic [2:0] v, input logic back);
        logic [2:0] r;
        if (back) begin
            r = (v == 3'd0) ? SIDE_LAST : v - 3'd1;
        end else begin
            r = (v == SIDE_LAST) ? 3'd0 : v + 3'd1;
        end
        return r;
    endfunction

    function automatic logic [4:0] cell_addr(input logic [2:0] row, input logic [2:0] col);
        return {row, 2'b00} + {2'b00, row} + {2'b00, col};
    endfunction

    // Memories: square letters and per-letter {row, col}
    logic [4:0] square_mem [CELLS];
    logic [5:0] pos_mem [LETTERS];

    logic             decrypt_reg;
    logic [LETTERS-1:0] present_reg;
    logic [4:0]       fill_reg;
    logic [2:0]       fill_row_reg;
    logic [2:0]       fill_col_reg;
    logic             ready_reg;
    logic [4:0]       walk_reg;
    logic [1:0]       cmd_q;
    logic [4:0]       a_q;
    logic [5:0]       pos_a_q, pos_b_q;
    logic [4:0]       sq_a_q, sq_b_q;
    logic [4:0]       out_a_reg, out_b_reg;
    logic [1:0]       status_reg;

    logic [1:0] key_status;
    logic [1:0] res_status;
    logic [4:0] res_a, res_b;
    logic       key_place;
    logic       walk_place;
    logic       place_en;
    logic [4:0] place_c;
    logic [2:0] r1, c1, r2, c2;
    logic [2:0] nr1, nc1, nr2, nc2;

    assign stat.cmd          = cmd_q;
    assign stat.square_ready = ready_reg;
    assign stat.walk_last    = (walk_reg == LAST_LETTER);

    // Key letter check
    always_comb begin
        if (ready_reg || (fill_reg >= CELLS_5B)) begin
            key_status = ST_FULL;
        end else if (present_reg[a_q]) begin
            key_status = ST_DUPLICATE;
        end else begin
            key_status = ST_DONE;
        end
    end

    // Pick the result for the current state
    always_comb begin
        res_a      = 5'd0;
        res_b      = 5'd0;
        res_status = ST_DONE;
        case (cmd.res_sel)
            RES_EXEC: begin
                case (cmd_q)
                    CMD_KEY:    res_status = key_status;
                    CMD_FINISH: res_status = ST_FULL;
                    CMD_PAIR:   res_status = ST_NOT_READY;
                    default:    res_status = ST_DONE;
                endcase
            end
            RES_SQ: begin
                res_a = sq_a_q;
                res_b = sq_b_q;
            end
            default: begin
                res_status = ST_DONE;
            end
        endcase
    end

    // Placement from a key letter or the finishing walk
    assign key_place  = cmd.fire && (cmd.res_sel == RES_EXEC) && (cmd_q == CMD_KEY)
                        && (key_status == ST_DONE);
    assign walk_place = cmd.walk_step && (walk_reg != LETTER_J) && (fill_reg < CELLS_5B)
                        && !present_reg[walk_reg];
    assign place_en   = key_place || walk_place;
    assign place_c    = key_place ? a_q : walk_reg;

    // Translate coordinates
    always_comb begin
        r1  = pos_a_q[5:3];
        c1  = pos_a_q[2:0];
        r2  = pos_b_q[5:3];
        c2  = pos_b_q[2:0];
        nr1 = r1;
        nc1 = c1;
        nr2 = r2;
        nc2 = c2;
        if (r1 == r2) begin
            nc1 = step_idx(c1, decrypt_reg);
            nc2 = step_idx(c2, decrypt_reg);
        end else if (c1 == c2) begin
            nr1 = step_idx(r1, decrypt_reg);
            nr2 = step_idx(r2, decrypt_reg);
        end else begin
            nc1 = c2;
            nc2 = c1;
        end
    end

    // Memory writes and registered reads
    always_ff @(posedge aclk) begin
        if (place_en) begin
            square_mem[fill_reg] <= place_c;
            pos_mem[place_c]     <= {fill_row_reg, fill_col_reg};
        end
        if (cmd.capture) begin
            pos_a_q <= pos_mem[norm_letter(s_letter_a)];
            pos_b_q <= pos_mem[norm_letter(s_letter_b)];
        end
        if (cmd.sq_read) begin
            sq_a_q <= square_mem[cell_addr(nr1, nc1)];
            sq_b_q <= square_mem[cell_addr(nr2, nc2)];
        end
    end

    // Capture the transaction and load the output register
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            cmd_q <= s_command;
            a_q   <= norm_letter(s_letter_a);
        end
        if (cmd.fire) begin
            out_a_reg  <= res_a;
            out_b_reg  <= res_b;
            status_reg <= res_status;
        end
    end

    // Square control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            decrypt_reg  <= 1'b0;
            present_reg  <= '0;
            fill_reg     <= 5'd0;
            fill_row_reg <= 3'd0;
            fill_col_reg <= 3'd0;
            ready_reg    <= 1'b0;
            walk_reg     <= 5'd0;
        end else begin
            if (cfg_wr_en) begin
                decrypt_reg <= cfg_wr_data;
            end
            if (place_en) begin
                present_reg[place_c] <= 1'b1;
                fill_reg             <= fill_reg + 5'd1;
                if (fill_col_reg == SIDE_LAST) begin
                    fill_col_reg <= 3'd0;
                    fill_row_reg <= fill_row_reg + 3'd1;
                end else begin
                    fill_col_reg <= fill_col_reg + 3'd1;
                end
            end
            if (cmd.walk_start) begin
                walk_reg <= 5'd0;
            end else if (cmd.walk_step) begin
                walk_reg <= walk_reg + 5'd1;
                if (walk_reg == LAST_LETTER) begin
                    ready_reg <= 1'b1;
                end
            end
        end
    end

    assign m_out_a  = out_a_reg;
    assign m_out_b  = out_b_reg;
    assign m_status = status_reg;

endmodule

// ===== hw/rtl/playfair_digraph_cipher_core.sv =====
`timescale 1ns / 1ps

// Playfair 5x5 digraph cipher core.
// Input channel s_*: s_command selects key letter, finish square, translate
// pair or no-op; s_letter_a / s_letter_b carry letters 0=a..25=z. Each
// transaction yields exactly one result on m_*: m_out_a, m_out_b and m_status.
// cfg_wr_en / cfg_wr_data write the decrypt bit; write only while idle.
// A key letter or a rejected command is decided in the execute state; a
// translated pair takes a position memory read, then a square memory read;
// a finish walks over the 26 letters, one per cycle, to fill the square.
// Throughput: one key letter per cycle while the receiver takes each result;
// the next transaction is taken in the cycle the current result is loaded.
// Reset clears the square (fill count, letter set, ready flag), the decrypt
// bit and the output valid; no clearing pass is needed.
// When the receiver stalls, the result is held in the output register; an idle
// core takes one more item and holds it, s_ready low until the register frees.

module playfair_digraph_cipher_core import pcf_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_command,
    input  logic [4:0] s_letter_a,
    input  logic [4:0] s_letter_b,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [4:0] m_out_a,
    output logic [4:0] m_out_b,
    output logic [1:0] m_status
);

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    pcf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    pcf_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_command   (s_command),
        .s_letter_a  (s_letter_a),
        .s_letter_b  (s_letter_b),
        .m_out_a     (m_out_a),
        .m_out_b     (m_out_b),
        .m_status    (m_status),
        .cmd         (cmd),
        .stat        (stat)
    );

endmodule
